>>> src/wcap_pkg.sv
// ============================================================================
// wcap_pkg: shared types and constants of the weighted class argmax block
// Holds the table geometry, the fixed-point constants, the register indexes
// and the word formats that travel between the pipeline stages.
// ============================================================================
package wcap_pkg;

    // Table geometry.
    localparam int MAX_CLASSES = 8;
    localparam int SLOT_W      = $clog2(MAX_CLASSES);
    localparam int COUNT_W     = $clog2(MAX_CLASSES + 1);

    // Field widths.
    localparam int SAMPLE_W = 32;
    localparam int WEIGHT_W = 17;
    localparam int LABEL_W  = 16;
    localparam int SCORE_W  = 49;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    // Fixed-point constants: weight 1.0 in Q1.16 and score -1.0 in Q17.32.
    localparam logic signed [SAMPLE_W-1:0] WEIGHT_ONE = 32'sh0001_0000;
    localparam logic signed [SCORE_W-1:0]  SCORE_MINUS_ONE = -(49'sd1 <<< 32);

    // Result queue depth; it must cover the words still in the pipeline.
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Item function codes.
    typedef enum logic {
        FUNC_LOAD    = 1'b0,
        FUNC_ELEMENT = 1'b1
    } func_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOFT_MODE    = 2'd0,
        REG_CLASS_COUNT  = 2'd1,
        REG_NODATA_CHECK = 2'd2,
        REG_NODATA_VALUE = 2'd3
    } cfg_reg_t;

    // Control flags that follow an element down the pipeline.
    typedef struct packed {
        logic first;
        logic last;
    } elem_ctl_t;

    // One result word as held in the output queue.
    typedef struct packed {
        logic                       is_nodata;
        logic signed [SAMPLE_W-1:0] result;
    } result_t;

endpackage

>>> src/weighted_class_argmax_per_pixel.sv
// ============================================================================
// weighted_class_argmax_per_pixel: per-pixel weighted argmax over classes
// Stores a weight and a label per class in two small synchronous tables and
// reduces each pixel's run of class potentials to a label, the largest
// potential or the no-data marker.
// ============================================================================
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  input   | in_valid, in_ready, func, class_slot,          | in
//          | sample_value, class_label                      |
//  output  | out_valid, out_ready, pixel_result,            | out
//          | pixel_is_nodata                                |
//  config  | cfg_write, cfg_index, cfg_data                 | in
//
//  One input word is taken every cycle while in_ready is high. The tables are
//  read at the accept edge, the weighted score is formed in the next stage
//  and the running best is updated in the stage after, from which a pixel's
//  result is written into the queue. A four-word result queue decouples the
//  output; input is held off only while the queue and the two stages in
//  flight could fill it. Reset clears control state and loads the register
//  defaults; the tables are not cleared and must be loaded before use.
//
module weighted_class_argmax_per_pixel (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration port.
    input  logic                          cfg_write,
    input  logic [wcap_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wcap_pkg::CFG_W-1:0]    cfg_data,
    // Input channel.
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic [2:0]                    class_slot,
    input  logic signed [31:0]            sample_value,
    input  logic [15:0]                   class_label,
    // Output channel.
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [31:0]            pixel_result,
    output logic                          pixel_is_nodata
);
    import wcap_pkg::*;

    // ------------------------------------------------------------------
    // Declarations.
    // ------------------------------------------------------------------
    logic                       soft_mode_reg;
    logic [COUNT_W-1:0]         class_count_reg;
    logic                       nodata_check_reg;
    logic signed [SAMPLE_W-1:0] nodata_value_reg;

    logic [WEIGHT_W-1:0]        weight_mem [MAX_CLASSES];
    logic [LABEL_W-1:0]         label_mem  [MAX_CLASSES];

    logic                       in_accept;
    logic                       load_accept;
    logic                       elem_accept;
    logic [WEIGHT_W-1:0]        weight_sat;
    logic [COUNT_W-1:0]         count_eff;
    logic [COUNT_W-1:0]         index_inc;
    logic                       elem_last;

    logic [COUNT_W-1:0]         element_index_reg;
    logic [COUNT_W-1:0]         element_index_next;

    // Stage 1: table read data and the element.
    logic                       s1_valid_reg;
    elem_ctl_t                  s1_ctl_reg;
    logic signed [SAMPLE_W-1:0] s1_sample_reg;
    logic [WEIGHT_W-1:0]        s1_weight_reg;
    logic [LABEL_W-1:0]         s1_label_reg;
    logic signed [SCORE_W-1:0]  s1_product;

    // Stage 2: weighted score.
    logic                       s2_valid_reg;
    elem_ctl_t                  s2_ctl_reg;
    logic signed [SAMPLE_W-1:0] s2_sample_reg;
    logic signed [SCORE_W-1:0]  s2_score_reg;
    logic [LABEL_W-1:0]         s2_label_reg;

    // Running pixel state.
    logic signed [SCORE_W-1:0]  best_score_reg;
    logic signed [SCORE_W-1:0]  best_score_next;
    logic [LABEL_W-1:0]         best_label_reg;
    logic [LABEL_W-1:0]         best_label_next;
    logic signed [SAMPLE_W-1:0] running_max_reg;
    logic signed [SAMPLE_W-1:0] running_max_next;
    logic                       saw_nodata_reg;
    logic                       saw_nodata_next;

    logic signed [SCORE_W-1:0]  best_cur;
    logic signed [SAMPLE_W-1:0] max_cur;
    logic                       score_wins;
    logic                       push;
    result_t                    push_word;

    // Result queue.
    result_t                    queue_mem [QDEPTH];
    logic [QPTR_W-1:0]          wr_ptr_reg;
    logic [QPTR_W-1:0]          rd_ptr_reg;
    logic [QCNT_W-1:0]          q_count_reg;
    logic [QCNT_W-1:0]          q_count_next;
    logic [QCNT_W-1:0]          occupancy;
    logic                       pop;
    result_t                    head_word;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            soft_mode_reg    <= 1'b0;
            class_count_reg  <= COUNT_W'(2);
            nodata_check_reg <= 1'b0;
            nodata_value_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SOFT_MODE:    soft_mode_reg    <= cfg_data[0];
                REG_CLASS_COUNT:  class_count_reg  <= cfg_data[COUNT_W-1:0];
                REG_NODATA_CHECK: nodata_check_reg <= cfg_data[0];
                REG_NODATA_VALUE: nodata_value_reg <= $signed(cfg_data[SAMPLE_W-1:0]);
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input acceptance and element counting.
    // ------------------------------------------------------------------
    assign occupancy   = q_count_reg + QCNT_W'(s1_valid_reg) + QCNT_W'(s2_valid_reg);
    assign in_ready    = (occupancy < QCNT_W'(QDEPTH));
    assign in_accept   = in_valid && in_ready;
    assign load_accept = in_accept && (func_t'(func) == FUNC_LOAD);
    assign elem_accept = in_accept && (func_t'(func) == FUNC_ELEMENT);

    // Out-of-range class counts are clamped: zero to one, larger ones to the table size.
    always_comb
    begin
        if (class_count_reg == '0)
            count_eff = COUNT_W'(1);
        else if (class_count_reg > COUNT_W'(MAX_CLASSES))
            count_eff = COUNT_W'(MAX_CLASSES);
        else
            count_eff = class_count_reg;
    end

    assign index_inc = element_index_reg + COUNT_W'(1);
    assign elem_last = (index_inc >= count_eff);

    always_comb
    begin
        element_index_next = element_index_reg;
        if (elem_accept)
            element_index_next = elem_last ? '0 : index_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            element_index_reg <= '0;
        else
            element_index_reg <= element_index_next;
    end

    // Load weights are clamped to the range 0 to 1.0.
    always_comb
    begin
        if (sample_value < 0)
            weight_sat = '0;
        else if (sample_value > WEIGHT_ONE)
            weight_sat = WEIGHT_ONE[WEIGHT_W-1:0];
        else
            weight_sat = sample_value[WEIGHT_W-1:0];
    end

    // ------------------------------------------------------------------
    // Class tables: written by loads, read by elements at the accept edge.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (load_accept)
        begin
            weight_mem[class_slot] <= weight_sat;
            label_mem[class_slot]  <= class_label;
        end
    end

    always_ff @(posedge clk)
    begin
        if (elem_accept)
        begin
            s1_weight_reg <= weight_mem[element_index_reg[SLOT_W-1:0]];
            s1_label_reg  <= label_mem[element_index_reg[SLOT_W-1:0]];
        end
    end

    // Stage 1 control and payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= elem_accept;
    end

    always_ff @(posedge clk)
    begin
        if (elem_accept)
        begin
            s1_sample_reg    <= sample_value;
            s1_ctl_reg.first <= (element_index_reg == '0);
            s1_ctl_reg.last  <= elem_last;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 to 2: exact weighted score.
    // ------------------------------------------------------------------
    assign s1_product = SCORE_W'(s1_sample_reg) * SCORE_W'($signed({1'b0, s1_weight_reg}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_score_reg  <= s1_product;
            s2_sample_reg <= s1_sample_reg;
            s2_label_reg  <= s1_label_reg;
            s2_ctl_reg    <= s1_ctl_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: update the running best, maximum and no-data flag.
    // ------------------------------------------------------------------
    assign best_cur   = s2_ctl_reg.first ? SCORE_MINUS_ONE : best_score_reg;
    assign max_cur    = s2_ctl_reg.first ? '0 : running_max_reg;
    assign score_wins = (s2_score_reg > best_cur);

    always_comb
    begin
        best_score_next  = best_score_reg;
        best_label_next  = best_label_reg;
        running_max_next = running_max_reg;
        saw_nodata_next  = saw_nodata_reg;
        if (s2_valid_reg)
        begin
            // The first element's label is class 0's, win or not.
            best_score_next  = score_wins ? s2_score_reg : best_cur;
            best_label_next  = (score_wins || s2_ctl_reg.first) ? s2_label_reg
                                                                 : best_label_reg;
            running_max_next = (s2_sample_reg > max_cur) ? s2_sample_reg : max_cur;
            saw_nodata_next  = (!s2_ctl_reg.first && saw_nodata_reg) ||
                               (nodata_check_reg && (s2_sample_reg == nodata_value_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_score_reg  <= SCORE_MINUS_ONE;
            best_label_reg  <= '0;
            running_max_reg <= '0;
            saw_nodata_reg  <= 1'b0;
        end
        else
        begin
            best_score_reg  <= best_score_next;
            best_label_reg  <= best_label_next;
            running_max_reg <= running_max_next;
            saw_nodata_reg  <= saw_nodata_next;
        end
    end

    // The mode in force when the last element leaves stage 2 picks the result.
    assign push = s2_valid_reg && s2_ctl_reg.last;

    always_comb
    begin
        push_word.is_nodata = saw_nodata_next;
        if (saw_nodata_next)
            push_word.result = nodata_value_reg;
        else if (soft_mode_reg)
            push_word.result = running_max_next;
        else
            push_word.result = $signed({{(SAMPLE_W-LABEL_W){1'b0}}, best_label_next});
    end

    // ------------------------------------------------------------------
    // Result queue.
    // ------------------------------------------------------------------
    assign head_word = queue_mem[rd_ptr_reg];
    assign out_valid = (q_count_reg != '0);
    assign pop       = out_valid && out_ready;

    assign pixel_result    = head_word.result;
    assign pixel_is_nodata = head_word.is_nodata;

    always_ff @(posedge clk)
    begin
        if (push)
            queue_mem[wr_ptr_reg] <= push_word;
    end

    always_comb
    begin
        q_count_next = q_count_reg;
        if (push && !pop)
            q_count_next = q_count_reg + QCNT_W'(1);
        else if (pop && !push)
            q_count_next = q_count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            q_count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            q_count_reg <= q_count_next;
        end
    end

endmodule
